/* hdl/conv3_pkg.sv */
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared types and constants of the clamped 3x3 image convolution block.
// ----------------------------------------------------------------------------
package conv3_pkg;

	localparam int MAX_LINE_WIDTH_DEF = 1024;
	localparam int WEIGHT_BITS_DEF    = 16;
	localparam int PIXEL_BITS         = 8;

	localparam int KERNEL_BITS    = 48;
	localparam int WEIGHT_FIELD   = 16;
	localparam int WIDTH_BITS     = 11;
	localparam int HEIGHT_BITS    = 12;
	localparam int SHIFT_BITS     = 4;
	localparam int ROW_BITS       = 12;
	localparam int OUT_COL_BITS   = 10;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 48;

	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_TOP    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RESULT_SHIFT  = 3'd5;

	localparam logic [KERNEL_BITS-1:0] KERNEL_TOP_RESET    = 48'h0;
	localparam logic [KERNEL_BITS-1:0] KERNEL_MIDDLE_RESET = 48'h10000;
	localparam logic [KERNEL_BITS-1:0] KERNEL_BOTTOM_RESET = 48'h0;
	localparam int                     WIDTH_RESET         = 1024;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET        = 12'd1024;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam int OFIFO_DEPTH    = 8;
	localparam int OFIFO_PTR_BITS = 3;

	typedef struct packed {
		logic                  cmd;
		logic [PIXEL_BITS-1:0] pixel_value;
	} pix_in_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0]   filtered_value;
		logic [ROW_BITS-1:0]     out_row;
		logic [OUT_COL_BITS-1:0] out_column;
		logic                    frame_last;
	} res_out_t;

	// Per-item control decided at the input transfer
	typedef struct packed {
		logic                    push;
		logic                    clr_pre;
		logic                    produce;
		logic                    last;
		logic [8:0]              mask;
		logic [ROW_BITS-1:0]     row;
		logic [OUT_COL_BITS-1:0] col;
	} ctrl_t;

endpackage

/* hdl/image_convolution_3x3_clamped_top.sv */
// A result for the input item that completes its window passes the steps
//   window/multiply, row sums, total, and clamp into queue, in that order.
// Throughput: one item per cycle; each line RAM takes one read and one write per
//   cycle. Input ready drops when queued plus in-flight results fill the 8-entry queue.
// Reset: counters, window and configuration return to defaults; line RAMs
//   are not cleared.
// ----------------------------------------------------------------------------
// image_convolution_3x3_clamped_top
// 3x3 zero-padded correlation over a raster grey stream with arithmetic
// shift and clamp, configured through a plain register write port.
// ----------------------------------------------------------------------------
module image_convolution_3x3_clamped_top #(
	parameter int MAX_LINE_WIDTH = conv3_pkg::MAX_LINE_WIDTH_DEF,
	parameter int WEIGHT_BITS    = conv3_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   pix_valid,
	output logic                                   pix_ready,
	input  conv3_pkg::pix_in_t                     pix_data,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output conv3_pkg::res_out_t                    res_data,
	input  logic                                   cfg_wr_en,
	input  logic [conv3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [conv3_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
	import conv3_pkg::*;

	localparam int CW = $clog2(MAX_LINE_WIDTH);
	localparam logic [WIDTH_BITS-1:0] WIDTH_INIT =
		WIDTH_BITS'((MAX_LINE_WIDTH < WIDTH_RESET) ? MAX_LINE_WIDTH : WIDTH_RESET);

	logic [2:0][KERNEL_BITS-1:0] kernel_q;
	logic [WIDTH_BITS-1:0]       width_q, width_wr;
	logic [HEIGHT_BITS-1:0]      height_q, height_wr;
	logic [SHIFT_BITS-1:0]       shift_q;
	logic                        restart;

	ctrl_t                 ctl;
	logic [CW-1:0]         line_addr;
	logic [PIXEL_BITS-1:0] line_pixel, col_up, col_mid, col_pix;
	logic                  accept, mac_valid;
	res_out_t              mac_res;
	logic [2:0]            inflight;
	logic [OFIFO_PTR_BITS:0] fifo_count;

	assign accept  = pix_valid && pix_ready;
	assign restart = cfg_wr_en && ((cfg_index == REG_IMAGE_WIDTH) ||
		(cfg_index == REG_IMAGE_HEIGHT));

	always_comb begin
		width_wr = cfg_wdata[WIDTH_BITS-1:0];
		if (width_wr == '0) begin
			width_wr = WIDTH_BITS'(1);
		end else if (32'(width_wr) > MAX_LINE_WIDTH) begin
			width_wr = WIDTH_BITS'(MAX_LINE_WIDTH);
		end
		height_wr = cfg_wdata[HEIGHT_BITS-1:0];
		if (height_wr == '0) begin
			height_wr = HEIGHT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q[0] <= KERNEL_TOP_RESET;
			kernel_q[1] <= KERNEL_MIDDLE_RESET;
			kernel_q[2] <= KERNEL_BOTTOM_RESET;
			width_q     <= WIDTH_INIT;
			height_q    <= HEIGHT_RESET;
			shift_q     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_KERNEL_TOP: begin
					kernel_q[0] <= cfg_wdata;
				end
				REG_KERNEL_MIDDLE: begin
					kernel_q[1] <= cfg_wdata;
				end
				REG_KERNEL_BOTTOM: begin
					kernel_q[2] <= cfg_wdata;
				end
				REG_IMAGE_WIDTH: begin
					width_q <= width_wr;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= height_wr;
				end
				REG_RESULT_SHIFT: begin
					shift_q <= cfg_wdata[SHIFT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// hold input while queued and in-flight results could overrun the queue
	assign pix_ready = ({1'b0, fifo_count} + (OFIFO_PTR_BITS+2)'(inflight)) <
		(OFIFO_PTR_BITS+2)'(OFIFO_DEPTH);

	conv3_ctrl #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (pix_data),
		.width     (width_q),
		.height    (height_q),
		.restart   (restart),
		.ctl       (ctl),
		.line_addr (line_addr),
		.line_pixel(line_pixel)
	);

	conv3_linebuf #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH)
	) u_linebuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && ctl.push),
		.addr   (line_addr),
		.pixel  (line_pixel),
		.col_up (col_up),
		.col_mid(col_mid),
		.col_pix(col_pix)
	);

	conv3_mac #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (accept),
		.ctl      (ctl),
		.restart  (restart),
		.kernel   (kernel_q),
		.shift    (shift_q),
		.col_up   (col_up),
		.col_mid  (col_mid),
		.col_pix  (col_pix),
		.res_valid(mac_valid),
		.res      (mac_res),
		.inflight (inflight)
	);

	conv3_ofifo u_ofifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mac_valid),
		.wr_data (mac_res),
		.rd_valid(res_valid),
		.rd_ready(res_ready),
		.rd_data (res_data),
		.count   (fifo_count)
	);

endmodule

/* hdl/conv3_ctrl.sv */
// ----------------------------------------------------------------------------
// conv3_ctrl
// Raster counters: decides for each item whether it is pushed, whether it
// yields a result, and the result's position, border mask and frame end.
// ----------------------------------------------------------------------------
module conv3_ctrl #(
	parameter int MAX_LINE_WIDTH = conv3_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  conv3_pkg::pix_in_t                     item,
	input  logic [conv3_pkg::WIDTH_BITS-1:0]       width,
	input  logic [conv3_pkg::HEIGHT_BITS-1:0]      height,
	input  logic                                   restart,
	output conv3_pkg::ctrl_t                       ctl,
	output logic [$clog2(MAX_LINE_WIDTH)-1:0]      line_addr,
	output logic [conv3_pkg::PIXEL_BITS-1:0]       line_pixel
);
	import conv3_pkg::*;

	localparam int CW = $clog2(MAX_LINE_WIDTH);
	localparam int XW = (CW + 1 > WIDTH_BITS) ? CW + 1 : WIDTH_BITS;

	// input row runs up to height + 1 while the last drains go in
	logic [ROW_BITS:0]   in_row_q;
	logic [ROW_BITS-1:0] out_row_q;
	logic [CW-1:0]       in_col_q, out_col_q;

	logic                is_pix, row_ge_h, past_end, restart_frame;
	logic [ROW_BITS:0]   er, height_x, height_p1;
	logic [ROW_BITS-1:0] orow;
	logic [CW-1:0]       ec, ocol;
	logic [XW-1:0]       width_x, ec_nx, ocol_nx;
	logic                in_wrap, out_wrap, row_end, col_end;
	logic [2:0]          row_ok, col_ok;

	always_comb begin
		is_pix        = item.cmd == CMD_PIXEL;
		height_x      = {1'b0, height};
		height_p1     = height_x + (ROW_BITS+1)'(1);
		row_ge_h      = in_row_q >= height_x;
		past_end      = (in_row_q > height_p1) ||
			((in_row_q == height_p1) && (in_col_q != '0));
		restart_frame = is_pix && row_ge_h;
		er            = restart_frame ? '0 : in_row_q;
		ec            = restart_frame ? '0 : in_col_q;
		orow          = restart_frame ? '0 : out_row_q;
		ocol          = restart_frame ? '0 : out_col_q;
		width_x       = XW'(width);
		ec_nx         = XW'(ec) + XW'(1);
		ocol_nx       = XW'(ocol) + XW'(1);
		in_wrap       = ec_nx >= width_x;
		out_wrap      = ocol_nx >= width_x;
		row_end       = ({1'b0, orow} + (ROW_BITS+1)'(1)) == {1'b0, height};
		col_end       = ocol_nx == width_x;
		row_ok        = {({1'b0, orow} + (ROW_BITS+1)'(1)) < {1'b0, height}, 1'b1, orow != '0};
		col_ok        = {ocol_nx < width_x, 1'b1, ocol != '0};

		ctl.push    = is_pix || (row_ge_h && !past_end);
		ctl.clr_pre = restart_frame;
		ctl.produce = ctl.push && !((er == '0) || ((er == (ROW_BITS+1)'(1)) && (ec == '0)));
		ctl.last    = ctl.produce && row_end && col_end;
		for (int k = 0; k < 9; k++) begin
			ctl.mask[k] = row_ok[k / 3] & col_ok[k % 3];
		end
		ctl.row = orow;
		ctl.col = OUT_COL_BITS'(ocol);

		line_addr  = ec;
		line_pixel = is_pix ? item.pixel_value : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (restart) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (accept && ctl.push) begin
			if (ctl.last) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				in_col_q <= in_wrap ? '0 : CW'(ec_nx);
				in_row_q <= in_wrap ? er + (ROW_BITS+1)'(1) : er;
				if (ctl.produce) begin
					out_col_q <= out_wrap ? '0 : CW'(ocol_nx);
					out_row_q <= out_wrap ? orow + ROW_BITS'(1) : orow;
				end else begin
					out_col_q <= ocol;
					out_row_q <= orow;
				end
			end
		end
	end

endmodule

/* hdl/conv3_linebuf.sv */
// ----------------------------------------------------------------------------
// conv3_linebuf
// Two line stores in synchronous RAM. Each pushed column reads both lines,
// then writes middle into upper and the new pixel into middle.
// ----------------------------------------------------------------------------
module conv3_linebuf #(
	parameter int MAX_LINE_WIDTH = conv3_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [$clog2(MAX_LINE_WIDTH)-1:0]   addr,
	input  logic [conv3_pkg::PIXEL_BITS-1:0]    pixel,
	output logic [conv3_pkg::PIXEL_BITS-1:0]    col_up,
	output logic [conv3_pkg::PIXEL_BITS-1:0]    col_mid,
	output logic [conv3_pkg::PIXEL_BITS-1:0]    col_pix
);
	import conv3_pkg::*;

	localparam int CW = $clog2(MAX_LINE_WIDTH);

	logic [PIXEL_BITS-1:0] upper_mem  [MAX_LINE_WIDTH];
	logic [PIXEL_BITS-1:0] middle_mem [MAX_LINE_WIDTH];

	logic                  v_s1;
	logic [CW-1:0]         addr_s1;
	logic [PIXEL_BITS-1:0] pix_s1, up_rd_s1, mid_rd_s1, fwd_up_s1, fwd_mid_s1;
	logic                  fwd_s1;

	// Same column written by the item in s1 while being read: take the write data
	assign col_up  = fwd_s1 ? fwd_up_s1 : up_rd_s1;
	assign col_mid = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;
	assign col_pix = pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			up_rd_s1   <= upper_mem[addr];
			mid_rd_s1  <= middle_mem[addr];
			addr_s1    <= addr;
			pix_s1     <= pixel;
			fwd_s1     <= v_s1 && (addr_s1 == addr);
			fwd_up_s1  <= col_mid;
			fwd_mid_s1 <= pix_s1;
		end
		if (v_s1) begin
			upper_mem[addr_s1]  <= col_mid;
			middle_mem[addr_s1] <= pix_s1;
		end
	end

endmodule

/* hdl/conv3_mac.sv */
// ----------------------------------------------------------------------------
// conv3_mac
// 3x3 window, nine weight products, summing tree, arithmetic shift and
// clamp to the pixel range.
// ----------------------------------------------------------------------------
module conv3_mac #(
	parameter int WEIGHT_BITS = conv3_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          issue,
	input  conv3_pkg::ctrl_t                              ctl,
	input  logic                                          restart,
	input  logic [2:0][conv3_pkg::KERNEL_BITS-1:0]        kernel,
	input  logic [conv3_pkg::SHIFT_BITS-1:0]              shift,
	input  logic [conv3_pkg::PIXEL_BITS-1:0]              col_up,
	input  logic [conv3_pkg::PIXEL_BITS-1:0]              col_mid,
	input  logic [conv3_pkg::PIXEL_BITS-1:0]              col_pix,
	output logic                                          res_valid,
	output conv3_pkg::res_out_t                           res,
	output logic [2:0]                                    inflight
);
	import conv3_pkg::*;

	localparam int PW = WEIGHT_BITS + PIXEL_BITS + 1;
	localparam int RW = PW + 2;
	localparam int SW = PW + 4;

	ctrl_t                 c_s1;
	logic                  v_s1, v_s2, v_s3, v_s4;
	res_out_t              meta_s2, meta_s3, meta_s4;
	logic [PIXEL_BITS-1:0] win_q [9];
	logic [PIXEL_BITS-1:0] base  [9];
	logic [PIXEL_BITS-1:0] wn    [9];
	logic signed [WEIGHT_BITS-1:0] wgt [9];
	logic signed [PW-1:0]  prod    [9];
	logic signed [PW-1:0]  prod_s2 [9];
	logic signed [RW-1:0]  rsum_s3 [3];
	logic signed [SW-1:0]  total_s4, shifted;
	logic                  v1p;

	assign v1p = v_s1 && c_s1.produce;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			base[k] = c_s1.clr_pre ? '0 : win_q[k];
		end
		// shift the window one column left, new column on the right
		wn[0] = base[1];
		wn[1] = base[2];
		wn[2] = col_up;
		wn[3] = base[4];
		wn[4] = base[5];
		wn[5] = col_mid;
		wn[6] = base[7];
		wn[7] = base[8];
		wn[8] = col_pix;
		for (int k = 0; k < 9; k++) begin
			wgt[k]  = $signed(kernel[k / 3][WEIGHT_FIELD * (k % 3) +: WEIGHT_BITS]);
			prod[k] = $signed({1'b0, (c_s1.mask[k] ? wn[k] : {PIXEL_BITS{1'b0}})}) * wgt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			v_s1 <= issue && ctl.push;
			v_s2 <= v1p;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (restart) begin
				for (int k = 0; k < 9; k++) begin
					win_q[k] <= '0;
				end
			end else if (v_s1) begin
				for (int k = 0; k < 9; k++) begin
					win_q[k] <= c_s1.last ? '0 : wn[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			c_s1 <= ctl;
		end
		prod_s2 <= prod;
		meta_s2.filtered_value <= '0;
		meta_s2.out_row        <= c_s1.row;
		meta_s2.out_column     <= c_s1.col;
		meta_s2.frame_last     <= c_s1.last;
		for (int r = 0; r < 3; r++) begin
			rsum_s3[r] <= RW'(prod_s2[3*r]) + RW'(prod_s2[3*r+1]) + RW'(prod_s2[3*r+2]);
		end
		meta_s3  <= meta_s2;
		total_s4 <= SW'(rsum_s3[0]) + SW'(rsum_s3[1]) + SW'(rsum_s3[2]);
		meta_s4  <= meta_s3;
	end

	always_comb begin
		shifted = total_s4 >>> shift;
		res     = meta_s4;
		if (total_s4 <= 0) begin
			res.filtered_value = '0;
		end else if (shifted > $signed(SW'(255))) begin
			res.filtered_value = '1;
		end else begin
			res.filtered_value = shifted[PIXEL_BITS-1:0];
		end
	end

	assign res_valid = v_s4;
	assign inflight  = 3'(v1p) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);

endmodule

/* hdl/conv3_ofifo.sv */
// ----------------------------------------------------------------------------
// conv3_ofifo
// Small result queue that decouples the free-running pipeline from the
// consumer's ready.
// ----------------------------------------------------------------------------
module conv3_ofifo (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  conv3_pkg::res_out_t                  wr_data,
	output logic                                 rd_valid,
	input  logic                                 rd_ready,
	output conv3_pkg::res_out_t                  rd_data,
	output logic [conv3_pkg::OFIFO_PTR_BITS:0]   count
);
	import conv3_pkg::*;

	res_out_t                  mem [OFIFO_DEPTH];
	logic [OFIFO_PTR_BITS-1:0] wptr_q, rptr_q;
	logic [OFIFO_PTR_BITS:0]   cnt_q;
	logic                      pop;

	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem[rptr_q];
	assign count    = cnt_q;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + OFIFO_PTR_BITS'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + OFIFO_PTR_BITS'(1);
			end
			if (wr_en && !pop) begin
				cnt_q <= cnt_q + (OFIFO_PTR_BITS+1)'(1);
			end else if (pop && !wr_en) begin
				cnt_q <= cnt_q - (OFIFO_PTR_BITS+1)'(1);
			end
		end
	end

endmodule
